// ===== design/spz_pkg.sv =====
// Shared constants for the spread z-score signal core.
// Widths of the stream fields, register indexes, signal codes and multiplier sizes.
// No dependencies.
package spz_pkg;

    localparam int WINDOW_DEF     = 8;
    localparam int PRICE_BITS_DEF = 24;

    localparam int PRICE_W      = 24;
    localparam int SPREAD_OUT_W = 25;
    localparam int SIG_W        = 2;
    localparam int THR_W        = 10;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 32;
    localparam int CFG_IDX_W    = 8;

    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CMP_W  = PROD_W + MUL_W;

    localparam logic [MUL_W-1:0] DEC_SCALE = MUL_W'(10000);

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT  = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0] ENTRY_RESET = THR_W'(100);
    localparam logic [THR_W-1:0] EXIT_RESET  = THR_W'(80);

    localparam logic [SIG_W-1:0] SIG_ABOVE = 2'd0;
    localparam logic [SIG_W-1:0] SIG_BELOW = 2'd1;
    localparam logic [SIG_W-1:0] SIG_EXIT  = 2'd2;
    localparam logic [SIG_W-1:0] SIG_HOLD  = 2'd3;

endpackage

// ===== design/spz_win_mem.sv =====
// Spread window storage: one synchronous write port, one registered read port.
// Depends on nothing; sized by the top level.
module spz_win_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 25,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/spz_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on spz_pkg for operand and product widths.
module spz_mul
    import spz_pkg::*;
(
    input  logic              i_clk,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_p
);

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== design/spread_zscore_signal_core.sv =====
// Top level of the spread z-score signal core: sequencer, running sums, classifier.
// Depends on spz_pkg, spz_win_mem and spz_mul.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  price_a, price_b
//  m_axis    out        m_axis_tvalid / m_axis_tready  signal, spread_now
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// A full window gives a result as the last step completes, and the input reopens in the same
// cycle: twelve products run through the single 32x32 multiplier, one per cycle, then decide.
// The window entry is read when the request is accepted and written back at the end.
// Reset clears sums, fill count and write slot and loads default thresholds; the window
// memory is not cleared, entries are only used once written. A result waiting on m_axis
// stalls only the final step of the next request.
module spread_zscore_signal_core
    import spz_pkg::*;
#(
    parameter int WINDOW     = WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // price_a, price_b
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // signal, spread_now, zero pad
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [THR_W-1:0]       i_cfg_data
);

    localparam int SPW  = PRICE_BITS + 1;
    localparam int LW   = $clog2(WINDOW);
    localparam int SLW  = $clog2(WINDOW);
    localparam int FCW  = $clog2(WINDOW + 1);
    localparam int SUMW = PRICE_BITS + LW + 1;
    localparam int DW   = SUMW + 1;
    localparam int S2W  = 2 * PRICE_BITS;
    localparam int SQW  = 2 * PRICE_BITS + LW;
    localparam int D2W  = 2 * (DW - 1);
    localparam int VW   = 2 * PRICE_BITS + 2 * LW;
    localparam int T2W  = 2 * THR_W;

    typedef enum logic [14:0] {
        ST_IDLE = 15'h0001,
        ST_SS   = 15'h0002,
        ST_OO   = 15'h0004,
        ST_DD   = 15'h0008,
        ST_UU   = 15'h0010,
        ST_EE   = 15'h0020,
        ST_XX   = 15'h0040,
        ST_L0   = 15'h0080,
        ST_L1   = 15'h0100,
        ST_E0   = 15'h0200,
        ST_E1   = 15'h0400,
        ST_X0   = 15'h0800,
        ST_X1   = 15'h1000,
        ST_WB   = 15'h2000,
        ST_FIN  = 15'h4000
    } t_state;

    t_state r_state, n_state;
    t_state r_wb;

    logic signed [SPW-1:0]  r_s;
    logic signed [DW-1:0]   r_d;
    logic [S2W-1:0]         r_s2;
    logic [S2W-1:0]         r_o2;
    logic [D2W-1:0]         r_d2;
    logic [VW-1:0]          r_v;
    logic [T2W-1:0]         r_te2;
    logic [T2W-1:0]         r_tx2;
    logic [PROD_W-1:0]      r_acc;
    logic [CMP_W-1:0]       r_lhs;
    logic [CMP_W-1:0]       r_rhs_e;
    logic [CMP_W-1:0]       r_rhs_x;
    logic signed [SUMW-1:0] r_sum;
    logic [SQW-1:0]         r_sumsq;
    logic [SLW-1:0]         r_slot;
    logic [FCW-1:0]         r_fill;
    logic [THR_W-1:0]       r_entry;
    logic [THR_W-1:0]       r_exit;
    logic                   r_out_valid;
    logic [SIG_W-1:0]       r_out_sig;
    logic [SPREAD_OUT_W-1:0] r_out_spread;

    logic [PRICE_BITS-1:0]  price_a;
    logic [PRICE_BITS-1:0]  price_b;
    logic signed [SPW-1:0]  spread_in;
    logic                   in_fire;
    logic                   full;
    logic                   fin_go;
    logic [SPW-1:0]         rd_data;
    logic signed [SPW-1:0]  old_s;
    logic [SPW-1:0]         abs_s;
    logic [SPW-1:0]         abs_old;
    logic [SUMW-1:0]        abs_sum;
    logic [DW-1:0]          abs_d;
    logic [PROD_W-1:0]      d2_ext;
    logic [PROD_W-1:0]      v_ext;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [CMP_W-1:0]       acc_sum;
    logic                   d_pos;
    logic                   d_neg;
    logic [SIG_W-1:0]       sig;

    assign price_a   = s_axis_tdata[PRICE_BITS-1:0];
    assign price_b   = s_axis_tdata[PRICE_W+PRICE_BITS-1:PRICE_W];
    assign spread_in = $signed({1'b0, price_a}) - $signed({1'b0, price_b});

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign full          = (r_fill == FCW'(WINDOW));
    assign fin_go        = (r_state == ST_FIN) && (!full || !r_out_valid || m_axis_tready);

    // read at accept, write back at the end; requests never overlap
    spz_win_mem #(
        .DEPTH (WINDOW),
        .WIDTH (SPW),
        .AW    (SLW)
    ) u_win_mem (
        .i_clk     (i_clk),
        .i_wr_en   (fin_go),
        .i_wr_addr (r_slot),
        .i_wr_data (r_s),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_slot),
        .o_rd_data (rd_data)
    );

    assign old_s   = $signed(rd_data);
    assign abs_s   = r_s[SPW-1] ? SPW'(-r_s) : SPW'(r_s);
    assign abs_old = old_s[SPW-1] ? SPW'(-old_s) : SPW'(old_s);
    assign abs_sum = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign abs_d   = r_d[DW-1] ? DW'(-r_d) : DW'(r_d);
    assign d2_ext  = PROD_W'(r_d2);
    assign v_ext   = PROD_W'(r_v);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SS: begin
                mul_a = MUL_W'(abs_s);
                mul_b = MUL_W'(abs_s);
            end
            ST_OO: begin
                mul_a = MUL_W'(abs_old);
                mul_b = MUL_W'(abs_old);
            end
            ST_DD: begin
                mul_a = MUL_W'(abs_d);
                mul_b = MUL_W'(abs_d);
            end
            ST_UU: begin
                mul_a = MUL_W'(abs_sum);
                mul_b = MUL_W'(abs_sum);
            end
            ST_EE: begin
                mul_a = MUL_W'(r_entry);
                mul_b = MUL_W'(r_entry);
            end
            ST_XX: begin
                mul_a = MUL_W'(r_exit);
                mul_b = MUL_W'(r_exit);
            end
            ST_L0: begin
                mul_a = d2_ext[MUL_W-1:0];
                mul_b = DEC_SCALE;
            end
            ST_L1: begin
                mul_a = d2_ext[PROD_W-1:MUL_W];
                mul_b = DEC_SCALE;
            end
            ST_E0: begin
                mul_a = MUL_W'(r_te2);
                mul_b = v_ext[MUL_W-1:0];
            end
            ST_E1: begin
                mul_a = MUL_W'(r_te2);
                mul_b = v_ext[PROD_W-1:MUL_W];
            end
            ST_X0: begin
                mul_a = MUL_W'(r_tx2);
                mul_b = v_ext[MUL_W-1:0];
            end
            ST_X1: begin
                mul_a = MUL_W'(r_tx2);
                mul_b = v_ext[PROD_W-1:MUL_W];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    spz_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign acc_sum = CMP_W'(r_acc) + {mul_p, {MUL_W{1'b0}}};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_fire) n_state = ST_SS;
            ST_SS:   n_state = ST_OO;
            ST_OO:   n_state = ST_DD;
            ST_DD:   n_state = ST_UU;
            ST_UU:   n_state = ST_EE;
            ST_EE:   n_state = ST_XX;
            ST_XX:   n_state = ST_L0;
            ST_L0:   n_state = ST_L1;
            ST_L1:   n_state = ST_E0;
            ST_E0:   n_state = ST_E1;
            ST_E1:   n_state = ST_X0;
            ST_X0:   n_state = ST_X1;
            ST_X1:   n_state = ST_WB;
            ST_WB:   n_state = ST_FIN;
            ST_FIN:  if (fin_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign d_pos = !r_d[DW-1] && (r_d != '0);
    assign d_neg = r_d[DW-1];

    always_comb begin
        if (d_pos && (r_lhs > r_rhs_e)) begin
            sig = SIG_ABOVE;
        end else if (d_neg && (r_lhs > r_rhs_e)) begin
            sig = SIG_BELOW;
        end else if (r_lhs < r_rhs_x) begin
            sig = SIG_EXIT;
        end else begin
            sig = SIG_HOLD;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wb        <= ST_IDLE;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_entry     <= ENTRY_RESET;
            r_exit      <= EXIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wb    <= r_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ENTRY: r_entry <= i_cfg_data;
                    CFG_EXIT:  r_exit  <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (fin_go) begin
                r_sum   <= r_sum + SUMW'(r_s) - (full ? SUMW'(old_s) : SUMW'(0));
                r_sumsq <= r_sumsq + SQW'(r_s2) - (full ? SQW'(r_o2) : SQW'(0));
                r_slot  <= (r_slot == SLW'(WINDOW - 1)) ? SLW'(0) : r_slot + 1'b1;
                if (!full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (fin_go && full) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: product of state X is written back while r_wb == X
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s <= spread_in;
        end
        if (r_state == ST_SS) begin
            r_d <= DW'(r_s) * DW'(WINDOW) - DW'(r_sum);
        end
        case (r_wb)
            ST_SS: r_s2  <= S2W'(mul_p);
            ST_OO: r_o2  <= S2W'(mul_p);
            ST_DD: r_d2  <= D2W'(mul_p);
            ST_UU: r_v   <= VW'(r_sumsq) * VW'(WINDOW) - VW'(mul_p);
            ST_EE: r_te2 <= T2W'(mul_p);
            ST_XX: r_tx2 <= T2W'(mul_p);
            ST_L0: r_acc <= mul_p;
            ST_L1: r_lhs <= acc_sum;
            ST_E0: r_acc <= mul_p;
            ST_E1: r_rhs_e <= acc_sum;
            ST_X0: r_acc <= mul_p;
            ST_X1: r_rhs_x <= acc_sum;
            default: ;
        endcase
        if (fin_go && full) begin
            r_out_sig    <= sig;
            r_out_spread <= SPREAD_OUT_W'(r_s);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_spread, r_out_sig});

endmodule
